/* sv/mrfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types, codes and reset constants of the RTU frame controller.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned GAP_W            = 24;
  localparam int unsigned LEN_W            = 9;
  localparam int unsigned FUNC_W           = 3;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned STREAM_W         = 32;

  localparam logic [GAP_W-1:0] SILENCE_MAX     = {GAP_W{1'b1}};
  localparam logic [GAP_W-1:0] LONG_GAP_RST    = 24'd58333;
  localparam logic [GAP_W-1:0] SHORT_GAP_RST   = 24'd16667;
  localparam logic             USE_DE_RST      = 1'b1;

  // Operating mode, also the controller state
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_SEND = 2'd2
  } mode_e;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_RX_BYTE  = 3'd1,
    FUNC_WR_TX    = 3'd2,
    FUNC_SEND     = 3'd3,
    FUNC_RD_RX    = 3'd4,
    FUNC_ACK      = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_GAP  = 2'd0,
    CFG_SHORT_GAP = 2'd1,
    CFG_USE_DE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAP_W-1:0] long_gap;
    logic [GAP_W-1:0] short_gap;
    logic             use_de;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] buf_index;
    logic [LEN_W-1:0]  send_length;
    logic              tx_space;
    logic              tx_empty;
  } item_t;

  // Result fields known at accept time; buffer bytes join in the following cycle
  typedef struct packed {
    logic             tx_valid;
    logic             rd_hit;
    logic             driver_enable;
    logic             frame_ready;
    logic [LEN_W-1:0] frame_length;
    logic             status;
    mode_e            mode;
  } res_meta_t;

endpackage

/* sv/mrfc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_ram
// Byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrfc_ram
  import mrfc_pkg::*;
#(
  parameter int unsigned DEPTH  = BUFFER_DEPTH_DEF,
  parameter int unsigned DATA_W = BYTE_W,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/mrfc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_ctrl
// Mode state machine, counters and buffer access decode per transfer.
// ----------------------------------------------------------------------------
module mrfc_ctrl
  import mrfc_pkg::*;
#(
  parameter int unsigned DEPTH  = BUFFER_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  output res_meta_t         meta_o,
  output logic              rx_wr_en_o,
  output logic [ADDR_W-1:0] rx_wr_addr_o,
  output logic              rx_rd_en_o,
  output logic [ADDR_W-1:0] rx_rd_addr_o,
  output logic              tx_wr_en_o,
  output logic [ADDR_W-1:0] tx_wr_addr_o,
  output logic              tx_rd_en_o,
  output logic [ADDR_W-1:0] tx_rd_addr_o
);

  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_N  = CNT_W'(DEPTH - 1);

  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [CNT_W-1:0] tx_cnt_q, tx_cnt_d;
  logic [CNT_W-1:0] tx_pos_q, tx_pos_d;
  logic [GAP_W-1:0] sil_q, sil_d;
  logic             ready_q, ready_d;

  logic [GAP_W-1:0] sil_inc;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] len_ext;
  logic             idx_ok;
  logic [CNT_W-1:0] rx_base;
  logic [CNT_W-1:0] rx_wr_idx;
  logic             tx_issue;
  logic             status;

  assign sil_inc = (sil_q == SILENCE_MAX) ? sil_q : sil_q + GAP_W'(1);
  assign idx_ext = CMP_W'(item_i.buf_index);
  assign len_ext = CMP_W'(item_i.send_length);
  assign idx_ok  = idx_ext < DEPTH_C;
  assign rx_base = (mode_q == MODE_IDLE) ? '0 : rx_cnt_q;
  assign rx_wr_idx = (rx_base >= DEPTH_N) ? LAST_N : rx_base;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      rx_cnt_q <= '0;
      tx_cnt_q <= '0;
      tx_pos_q <= '0;
      sil_q    <= '0;
      ready_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      rx_cnt_q <= rx_cnt_d;
      tx_cnt_q <= tx_cnt_d;
      tx_pos_q <= tx_pos_d;
      sil_q    <= sil_d;
      ready_q  <= ready_d;
    end
  end

  // next state and buffer requests
  always_comb begin
    mode_d     = mode_q;
    rx_cnt_d   = rx_cnt_q;
    tx_cnt_d   = tx_cnt_q;
    tx_pos_d   = tx_pos_q;
    sil_d      = sil_q;
    ready_d    = ready_q;
    tx_issue   = 1'b0;
    status     = 1'b0;
    rx_wr_en_o = 1'b0;
    rx_rd_en_o = 1'b0;
    tx_wr_en_o = 1'b0;
    if (accept_i) begin
      case (item_i.func)
        FUNC_TICK: begin
          sil_d = sil_inc;
          if (mode_q == MODE_RECV) begin
            if (sil_inc > cfg_i.long_gap) begin
              ready_d = 1'b1;
              mode_d  = MODE_IDLE;
            end
          end else if (mode_q == MODE_SEND) begin
            if (tx_pos_q < tx_cnt_q) begin
              if (item_i.tx_space) begin
                tx_issue = 1'b1;
                tx_pos_d = tx_pos_q + CNT_W'(1);
                sil_d    = '0;
              end
            end else if (sil_inc > cfg_i.short_gap && item_i.tx_empty) begin
              mode_d = MODE_IDLE;
            end
          end
        end
        FUNC_RX_BYTE: begin
          // half duplex: bytes seen while sending are dropped
          if (mode_q != MODE_SEND) begin
            sil_d      = '0;
            mode_d     = MODE_RECV;
            rx_wr_en_o = 1'b1;
            rx_cnt_d   = rx_wr_idx + CNT_W'(1);
          end
        end
        FUNC_WR_TX: begin
          tx_wr_en_o = idx_ok;
        end
        FUNC_SEND: begin
          if (mode_q != MODE_IDLE || item_i.send_length == '0) begin
            status = 1'b1;
          end else begin
            tx_cnt_d = (len_ext > DEPTH_C) ? DEPTH_N : CNT_W'(len_ext);
            tx_pos_d = '0;
            sil_d    = '0;
            mode_d   = MODE_SEND;
          end
        end
        FUNC_RD_RX: begin
          rx_rd_en_o = idx_ok;
        end
        FUNC_ACK: begin
          ready_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign tx_rd_en_o   = tx_issue;
  assign rx_wr_addr_o = rx_wr_idx[ADDR_W-1:0];
  assign rx_rd_addr_o = idx_ext[ADDR_W-1:0];
  assign tx_wr_addr_o = idx_ext[ADDR_W-1:0];
  assign tx_rd_addr_o = tx_pos_q[ADDR_W-1:0];

  // result fields after the update
  always_comb begin
    meta_o.tx_valid      = tx_issue;
    meta_o.rd_hit        = rx_rd_en_o;
    meta_o.driver_enable = (mode_d == MODE_SEND) && cfg_i.use_de;
    meta_o.frame_ready   = ready_d;
    meta_o.frame_length  = LEN_W'(rx_cnt_d);
    meta_o.status        = status;
    meta_o.mode          = mode_d;
  end

endmodule

/* sv/modbus_rtu_frame_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_controller
// Half-duplex RTU framer: receive/transmit byte buffers in RAM, silence
// timing, frame-ready flag and transceiver direction control.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  s_axis    in         tvalid/tready            tuser: func; tdata: item fields
//  m_axis    out        tvalid/tready            tuser: tx_valid; tdata: results
//  cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One item per clock unless both stages hold results and the output stalls.
//  A result passes the synchronous buffer read, then the output register.
//  Control state updates at the transfer, so the next item sees it at once;
//  buffer write and read of different items never share a cycle.
//  Reset clears mode, counters and flags; buffers are not cleared.
//  A stalled output holds the read stage; input stays open while either
//  stage is free.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_controller
  import mrfc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: data_byte[7:0], buf_index[15:8], send_length[24:16],
  //        tx_space[25], tx_empty[26], zero[31:27]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [STREAM_W-1:0]  s_axis_tdata,
  // tuser: func[2:0]
  input  logic [FUNC_W-1:0]    s_axis_tuser,
  // tdata: tx_byte[7:0], driver_enable[8], frame_ready[9], frame_length[18:10],
  //        read_data[26:19], status[27], mode[29:28], zero[31:30]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [STREAM_W-1:0]  m_axis_tdata,
  // tuser: tx_valid
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAP_W-1:0]     cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  cfg_t              cfg_q;
  item_t             item;
  res_meta_t         meta;
  res_meta_t         s1_meta_q;
  logic              s1_valid_q;
  logic              o_valid_q;
  logic [STREAM_W-1:0] o_data_q;
  logic              o_user_q;
  logic              accept;
  logic              s1_adv;
  logic              rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
  logic [ADDR_W-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
  logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;
  logic [BYTE_W-1:0] tx_byte, read_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_gap  <= LONG_GAP_RST;
      cfg_q.short_gap <= SHORT_GAP_RST;
      cfg_q.use_de    <= USE_DE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_GAP:  cfg_q.long_gap  <= cfg_data_i;
        CFG_SHORT_GAP: cfg_q.short_gap <= cfg_data_i;
        CFG_USE_DE:    cfg_q.use_de    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // input unpack
  always_comb begin
    item.func        = s_axis_tuser;
    item.data_byte   = s_axis_tdata[7:0];
    item.buf_index   = s_axis_tdata[15:8];
    item.send_length = s_axis_tdata[24:16];
    item.tx_space    = s_axis_tdata[25];
    item.tx_empty    = s_axis_tdata[26];
  end

  // pipeline flow
  assign s1_adv        = s1_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !o_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mrfc_ctrl #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .meta_o       (meta),
    .rx_wr_en_o   (rx_wr_en),
    .rx_wr_addr_o (rx_wr_addr),
    .rx_rd_en_o   (rx_rd_en),
    .rx_rd_addr_o (rx_rd_addr),
    .tx_wr_en_o   (tx_wr_en),
    .tx_wr_addr_o (tx_wr_addr),
    .tx_rd_en_o   (tx_rd_en),
    .tx_rd_addr_o (tx_rd_addr)
  );

  mrfc_ram #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (BYTE_W)
  ) u_rx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rx_wr_en),
    .wr_addr_i (rx_wr_addr),
    .wr_data_i (item.data_byte),
    .rd_en_i   (rx_rd_en),
    .rd_addr_i (rx_rd_addr),
    .rd_data_o (rx_rd_data)
  );

  mrfc_ram #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (BYTE_W)
  ) u_tx_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tx_wr_en),
    .wr_addr_i (tx_wr_addr),
    .wr_data_i (item.data_byte),
    .rd_en_i   (tx_rd_en),
    .rd_addr_i (tx_rd_addr),
    .rd_data_o (tx_rd_data)
  );

  // read stage: holds result fields while the buffer read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
  end

  assign tx_byte   = s1_meta_q.tx_valid ? tx_rd_data : '0;
  assign read_data = s1_meta_q.rd_hit ? rx_rd_data : '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (s1_adv) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      o_user_q <= s1_meta_q.tx_valid;
      o_data_q <= {2'b00, s1_meta_q.mode, s1_meta_q.status, read_data,
                   s1_meta_q.frame_length, s1_meta_q.frame_ready,
                   s1_meta_q.driver_enable, tx_byte};
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

endmodule

/* sv/mrfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_checker
// Port-level checks on the result stream of the frame controller.
// ----------------------------------------------------------------------------
module mrfc_checker
  import mrfc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [STREAM_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // driver enable only while sending
  a_de_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[29:28] == MODE_SEND)
    else $error("driver enable outside send mode");

  // an issued byte leaves the block in send mode
  a_tx_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[29:28] == MODE_SEND)
    else $error("tx byte issued outside send mode");

  // a byte issue and a send rejection never come from one item
  a_tx_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[27])
    else $error("tx byte together with rejected send");

  // no byte issued means a zero tx byte
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == '0)
    else $error("tx byte nonzero without issue");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind modbus_rtu_frame_controller mrfc_checker u_mrfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/framer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framer_checker
// Watches the item, result and register channels of the RTU frame
// controller. Runs its own model of the framer on every item transfer and
// compares each result transfer, field by field, with the oldest expected
// result. Hands the number of outstanding results and failures to the top.
// ----------------------------------------------------------------------------
module framer_checker
  import mrfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [STREAM_W-1:0]  in_data_i,
  input  logic [FUNC_W-1:0]    in_user_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [STREAM_W-1:0]  out_data_i,
  input  logic                 out_user_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAP_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);

  localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              driver_enable;
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;
    logic              status;
    logic [1:0]        mode;
  } framer_out_t;

  // Register copies
  logic [GAP_W-1:0] long_gap;
  logic [GAP_W-1:0] short_gap;
  logic             use_de;

  // Framer state copies
  mode_e             mode_q;
  logic [BYTE_W-1:0] rx_mem [DEPTH];
  logic [BYTE_W-1:0] tx_mem [DEPTH];
  logic [LEN_W-1:0]  rx_cnt;
  logic [LEN_W-1:0]  tx_len;
  logic [LEN_W-1:0]  tx_pos;
  logic [GAP_W-1:0]  silence;
  logic              rdy;

  framer_out_t due_results [$];
  int          n_errors = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("%0t: mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) note_mismatch(what, got, want);
  endtask

  // One item through the framer; returns the result it causes
  function automatic framer_out_t step_framer(input item_t it);
    framer_out_t r;
    r = '0;
    case (it.func)
      FUNC_TICK: begin
        if (silence != SILENCE_MAX) silence = silence + 1'b1;
        if (mode_q == MODE_RECV) begin
          // silence beyond the long gap closes the frame
          if (silence > long_gap) begin
            rdy    = 1'b1;
            mode_q = MODE_IDLE;
          end
        end else if (mode_q == MODE_SEND) begin
          if (tx_pos < tx_len) begin
            if (it.tx_space && tx_pos < DEPTH) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = tx_mem[tx_pos[BYTE_W-1:0]];
              tx_pos     = tx_pos + 1'b1;
              silence    = '0;
            end
          end else if (silence > short_gap && it.tx_empty) begin
            mode_q = MODE_IDLE;
          end
        end
      end
      FUNC_RX_BYTE: begin
        // half duplex: line input is dropped while sending
        if (mode_q != MODE_SEND) begin
          silence = '0;
          if (mode_q == MODE_IDLE) begin
            rx_cnt = '0;
            mode_q = MODE_RECV;
          end
          if (rx_cnt >= DEPTH) rx_cnt = LEN_W'(DEPTH - 1);
          rx_mem[rx_cnt[BYTE_W-1:0]] = it.data_byte;
          rx_cnt = rx_cnt + 1'b1;
        end
      end
      FUNC_WR_TX: begin
        if (it.buf_index < DEPTH) tx_mem[it.buf_index] = it.data_byte;
      end
      FUNC_SEND: begin
        if (mode_q != MODE_IDLE || it.send_length == '0) begin
          r.status = 1'b1;
        end else begin
          tx_len  = (it.send_length > DEPTH) ? LEN_W'(DEPTH) : it.send_length;
          tx_pos  = '0;
          silence = '0;
          mode_q  = MODE_SEND;
        end
      end
      FUNC_RD_RX: begin
        if (it.buf_index < DEPTH) r.read_data = rx_mem[it.buf_index];
      end
      FUNC_ACK: rdy = 1'b0;
      default: ;
    endcase
    r.driver_enable = (mode_q == MODE_SEND) && use_de;
    r.frame_ready   = rdy;
    r.frame_length  = rx_cnt;
    r.mode          = mode_q;
    return r;
  endfunction

  // Channel monitor: config, then item, then result transfer of this edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t       it;
    framer_out_t got;
    framer_out_t want;
    if (!rst_ni) begin
      long_gap  = LONG_GAP_RST;
      short_gap = SHORT_GAP_RST;
      use_de    = USE_DE_RST;
      mode_q    = MODE_IDLE;
      rx_cnt    = '0;
      tx_len    = '0;
      tx_pos    = '0;
      silence   = '0;
      rdy       = 1'b0;
      due_results.delete();
      pending_o <= 0;
      errors_o  <= n_errors;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LONG_GAP:  long_gap  = cfg_data_i;
          CFG_SHORT_GAP: short_gap = cfg_data_i;
          CFG_USE_DE:    use_de    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        it.func        = in_user_i;
        it.data_byte   = in_data_i[7:0];
        it.buf_index   = in_data_i[15:8];
        it.send_length = in_data_i[24:16];
        it.tx_space    = in_data_i[25];
        it.tx_empty    = in_data_i[26];
        due_results.push_back(step_framer(it));
      end
      if (out_valid_i && out_ready_i) begin
        got.tx_valid      = out_user_i;
        got.tx_byte       = out_data_i[7:0];
        got.driver_enable = out_data_i[8];
        got.frame_ready   = out_data_i[9];
        got.frame_length  = out_data_i[18:10];
        got.read_data     = out_data_i[26:19];
        got.status        = out_data_i[27];
        got.mode          = out_data_i[29:28];
        if (due_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = due_results.pop_front();
          check_field("tx_valid", got.tx_valid, want.tx_valid);
          check_field("tx_byte", got.tx_byte, want.tx_byte);
          check_field("driver_enable", got.driver_enable, want.driver_enable);
          check_field("frame_ready", got.frame_ready, want.frame_ready);
          check_field("frame_length", got.frame_length, want.frame_length);
          check_field("read_data", got.read_data, want.read_data);
          check_field("status", got.status, want.status);
          check_field("mode", got.mode, want.mode);
        end
      end
      pending_o <= due_results.size();
      errors_o  <= n_errors;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RTU frame controller. Fills both buffers,
// runs a short directed list (buffer overflow, busy and zero-length sends,
// half-duplex drop, unknown codes), then random frames, send bursts and
// noise under several register settings with random stalls on both sides
// and one long output hold-off. Checking is done by framer_checker.
// ----------------------------------------------------------------------------
module tb;
  import mrfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [STREAM_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]    s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [STREAM_W-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GAP_W-1:0]     cfg_data_i;

  int pending;
  int errors;

  // Stimulus side knowledge of the gap settings, for sizing tick bursts
  int unsigned long_gap_set  = LONG_GAP_RST;
  int unsigned short_gap_set = SHORT_GAP_RST;
  bit          calm          = 1'b0;
  int          hold_cycles   = 0;
  int          items_sent    = 0;
  int          cycles        = 0;

  modbus_rtu_frame_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  framer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Result side: random stalls, a calm stretch and one long hold-off
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // One item transfer, with random idle cycles ahead of it
  task automatic put_item(input logic [FUNC_W-1:0] f, input logic [7:0] d,
                          input logic [7:0] idx, input logic [LEN_W-1:0] len,
                          input logic sp, input logic em);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {5'b0, em, sp, len, idx, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic tick(input logic sp, input logic em);
    put_item(FUNC_TICK, 8'($urandom), 8'($urandom), 9'($urandom), sp, em);
  endtask

  task automatic rx_byte(input logic [7:0] d);
    put_item(FUNC_RX_BYTE, d, 8'($urandom), 9'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Enough silence to close a frame, unless the gap is out of reach
  task automatic close_frame();
    int n;
    n = (long_gap_set < 40) ? long_gap_set + 1 + $urandom_range(0, 2) : $urandom_range(1, 6);
    repeat (n) tick(1'($urandom), 1'($urandom));
  endtask

  // Ticks to stream len bytes, then the short gap with an empty line
  task automatic drain_send(input int len);
    int n;
    repeat (len + len / 8 + 2) tick($urandom_range(0, 9) != 0, 1'($urandom));
    n = (short_gap_set < 40) ? short_gap_set + 2 + $urandom_range(0, 2) : $urandom_range(1, 6);
    repeat (n) tick(1'($urandom), $urandom_range(0, 5) != 0);
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(input cfg_idx_e idx, input logic [GAP_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_gaps(input int unsigned lg, input int unsigned sg, input logic de);
    write_reg(CFG_LONG_GAP, GAP_W'(lg));
    write_reg(CFG_SHORT_GAP, GAP_W'(sg));
    write_reg(CFG_USE_DE, GAP_W'(de));
    long_gap_set  = lg;
    short_gap_set = sg;
  endtask

  // Mostly well-formed frames and send bursts, the rest noise
  task automatic random_traffic(input int n);
    int stop;
    int pick;
    int len;
    stop = items_sent + n;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        repeat (len) rx_byte(8'($urandom));
        close_frame();
        repeat ($urandom_range(0, 3))
          put_item(FUNC_RD_RX, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
                   1'($urandom));
        if ($urandom_range(0, 9) < 7)
          put_item(FUNC_ACK, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
                   1'($urandom));
      end else if (pick < 64) begin
        repeat ($urandom_range(0, 4))
          put_item(FUNC_WR_TX, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
                   1'($urandom));
        len = $urandom_range(1, 12);
        put_item(FUNC_SEND, 8'($urandom), 8'($urandom), 9'(len), 1'($urandom), 1'($urandom));
        drain_send(len);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12) : $urandom_range(0, 256);
          put_item(3'($urandom_range(0, 5)), 8'($urandom), 8'($urandom), 9'(len),
                   1'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_TICK;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_LONG_GAP;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_gaps(3, 2, 1'b1);

    // Fill the transmit buffer, then overflow the receive buffer
    for (int i = 0; i < 256; i++)
      put_item(FUNC_WR_TX, 8'($urandom), 8'(i), 9'($urandom), 1'($urandom), 1'($urandom));
    repeat (257) rx_byte(8'($urandom));
    close_frame();

    // Directed corners
    put_item(FUNC_RD_RX, 8'h00, 8'h00, 9'h000, 1'b0, 1'b0);
    put_item(FUNC_RD_RX, 8'hFF, 8'hFF, 9'h1FF, 1'b1, 1'b1);
    rx_byte(8'h00);                      // new frame over a pending one
    rx_byte(8'hFF);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b1);
    tick(1'b1, 1'b1);
    put_item(FUNC_ACK, 8'h00, 8'h00, 9'h000, 1'b0, 1'b0);
    put_item(FUNC_ACK, 8'hFF, 8'hFF, 9'h1FF, 1'b1, 1'b1);
    put_item(FUNC_SEND, 8'h00, 8'h00, 9'd0, 1'b1, 1'b1);      // zero length
    put_item(3'd6, 8'hA5, 8'h5A, 9'h0AA, 1'b1, 1'b0);         // unknown codes
    put_item(3'd7, 8'h5A, 8'hA5, 9'h155, 1'b0, 1'b1);
    put_item(FUNC_SEND, 8'h00, 8'h00, 9'd12, 1'b0, 1'b0);     // short send
    put_item(FUNC_SEND, 8'h00, 8'h00, 9'd1, 1'b0, 1'b0);      // busy
    rx_byte(8'h3C);                      // dropped while sending
    tick(1'b0, 1'b1);
    put_item(FUNC_WR_TX, 8'hC3, 8'hFF, 9'd0, 1'b0, 1'b0);
    drain_send(12);

    // No idling on either side
    calm = 1'b1;
    set_gaps(0, 0, 1'b0);
    random_traffic(50);
    calm = 1'b0;

    // A frame can never end
    set_gaps(GAP_W'('1), 3, 1'b1);
    random_traffic(30);

    // The driver is never released
    set_gaps(4, GAP_W'('1), 1'b1);
    random_traffic(30);

    // Long output hold-off while items keep coming
    set_gaps($urandom_range(1, 20), $urandom_range(1, 20), 1'($urandom));
    hold_cycles = 150;
    random_traffic(50);

    set_gaps($urandom_range(0, 30), $urandom_range(0, 30), 1'b0);
    random_traffic(30);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
